FILE: rtl/sacl_pkg.sv
`default_nettype none

package sacl_pkg;

  // fixed field widths
  localparam int unsigned ADDR_IN_W = 32;
  localparam int unsigned TAG_W     = 32;
  localparam int unsigned AGE_W     = 32;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned WAY_OUT_W = 3;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned SET_CFG_W  = 4;
  localparam int unsigned WAYS_CFG_W = 2;
  localparam int unsigned OFF_CFG_W  = 5;

  localparam logic [SET_CFG_W-1:0]  SET_BITS_RST  = 4'd6;
  localparam logic [WAYS_CFG_W-1:0] WAYS_LOG2_RST = 2'd2;
  localparam logic [OFF_CFG_W-1:0]  OFFSET_RST    = 5'd2;

  // default geometry
  localparam int unsigned DEF_MAX_SETS = 256;
  localparam int unsigned DEF_MAX_WAYS = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_BITS    = 2'd0,
    REG_WAYS_LOG2   = 2'd1,
    REG_OFFSET_BITS = 2'd2
  } reg_idx_e;

  // one cache entry as held in the arrays
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } entry_t;

  // verdict of the way unit for one scanned entry
  typedef struct packed {
    logic             hit;
    logic             fill;
    logic             take;
    logic             tag_we;
    entry_t           wr;
    logic [AGE_W-1:0] aged;
  } way_res_t;

  // saturating increment at all ones
  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == '1) ? v : v + 32'd1;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sacl_if.sv
`default_nettype none

// request channel: one word address
interface sacl_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

// response channel: lookup outcome and running counts
interface sacl_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [2:0]  way_used;
  logic        evicted;
  logic [31:0] hit_count;
  logic [31:0] access_count;

  modport source (output valid, output hit, output way_used, output evicted,
                  output hit_count, output access_count, input ready);
  modport sink (input valid, input hit, input way_used, input evicted,
                input hit_count, input access_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/sacl_mem.sv
`default_nettype none

module sacl_mem #(
  parameter int unsigned DEPTH  = 2048,
  parameter int unsigned ADDR_W = 11
) (
  input  wire logic                  clk_i,
  input  wire logic                  rd_en_i,
  input  wire logic [ADDR_W-1:0]     rd_addr_i,
  output sacl_pkg::entry_t           rd_o,
  input  wire logic                  we_i,
  input  wire logic                  tag_we_i,
  input  wire logic [ADDR_W-1:0]     wr_addr_i,
  input  wire sacl_pkg::entry_t      wr_i
);
  import sacl_pkg::*;

  logic             valid_mem [DEPTH];
  logic [TAG_W-1:0] tag_mem   [DEPTH];
  logic [AGE_W-1:0] age_mem   [DEPTH];
  entry_t           rd_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      valid_mem[wr_addr_i] <= wr_i.valid;
      age_mem[wr_addr_i]   <= wr_i.age;
      if (tag_we_i) begin
        tag_mem[wr_addr_i] <= wr_i.tag;
      end
    end
    if (rd_en_i) begin
      rd_q.valid <= valid_mem[rd_addr_i];
      rd_q.tag   <= tag_mem[rd_addr_i];
      rd_q.age   <= age_mem[rd_addr_i];
    end
  end

  assign rd_o = rd_q;

endmodule

`default_nettype wire

FILE: rtl/sacl_way_unit.sv
`default_nettype none

module sacl_way_unit (
  input  wire sacl_pkg::entry_t         rd_i,
  input  wire logic [31:0]              tag_i,
  input  wire logic                     done_i,
  input  wire logic                     first_i,
  input  wire logic [31:0]              oldest_age_i,
  output sacl_pkg::way_res_t            res_o
);
  import sacl_pkg::*;

  logic [AGE_W-1:0] aged;

  assign aged = sat_inc32(rd_i.age);

  // age the entry, then decide hit, fill or victim candidate
  always_comb begin
    res_o          = '0;
    res_o.aged     = aged;
    res_o.wr.valid = rd_i.valid;
    res_o.wr.tag   = rd_i.tag;
    res_o.wr.age   = aged;
    if (!done_i) begin
      if (rd_i.valid && (rd_i.tag == tag_i)) begin
        res_o.hit    = 1'b1;
        res_o.wr.age = '0;
      end else if (!rd_i.valid) begin
        res_o.fill     = 1'b1;
        res_o.tag_we   = 1'b1;
        res_o.wr.valid = 1'b1;
        res_o.wr.tag   = tag_i;
        res_o.wr.age   = '0;
      end else if (first_i || (aged > oldest_age_i)) begin
        res_o.take = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/set_assoc_cache_lru_lookup.sv
`default_nettype none

// Set-associative cache lookup with LRU replacement. Each request is a word
// address; the response gives hit, the way used, whether a valid line was
// evicted, and saturating hit and access counts. The ways of the selected
// set are visited one per cycle through one read port and one write port of
// the entry arrays and a shared age/compare unit, so a request keeps the
// block busy through S_PREP, S_SCAN and S_DONE, with an S_EVICT step added
// when a valid line has to be replaced. A finished response sits
// in an output register, so the next request may start while it waits.
// After reset the block clears valid bits and ages of all MAX_SETS * MAX_WAYS
// entries before it takes the first request; configuration writes are
// accepted throughout.
module set_assoc_cache_lru_lookup #(
  parameter int unsigned MAX_SETS = sacl_pkg::DEF_MAX_SETS,
  parameter int unsigned MAX_WAYS = sacl_pkg::DEF_MAX_WAYS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sacl_req_if.sink                             req,
  sacl_rsp_if.source                           rsp
);
  import sacl_pkg::*;

  localparam int unsigned ENTRIES      = MAX_SETS * MAX_WAYS;
  localparam int unsigned ADDR_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned SET_BITS_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned WAY_CNT_W    = $clog2(MAX_WAYS + 1);
  localparam int unsigned WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam logic [SET_CFG_W-1:0] SET_BITS_CAP = SET_CFG_W'(SET_BITS_MAX);
  localparam logic [ADDR_W-1:0]    LAST_ENTRY   = ADDR_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_EVICT,
    S_DONE
  } state_e;

  // configuration registers
  logic [SET_CFG_W-1:0]  set_bits_q;
  logic [WAYS_CFG_W-1:0] ways_log2_q;
  logic [OFF_CFG_W-1:0]  offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q  <= SET_BITS_RST;
      ways_log2_q <= WAYS_LOG2_RST;
      offset_q    <= OFFSET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SET_BITS:    set_bits_q  <= cfg_data_i[SET_CFG_W-1:0];
        REG_WAYS_LOG2:   ways_log2_q <= cfg_data_i[WAYS_CFG_W-1:0];
        REG_OFFSET_BITS: offset_q    <= cfg_data_i[OFF_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e                 state_q, state_d;
  logic [ADDR_W-1:0]      clr_q, clr_d;
  logic [ADDR_IN_W-1:0]   addr_q, addr_d;
  logic [TAG_W-1:0]       tag_q, tag_d;
  logic [ADDR_W-1:0]      base_q, base_d;
  logic [WAY_CNT_W-1:0]   ways_q, ways_d;
  logic [WAY_CNT_W-1:0]   rd_cnt_q, rd_cnt_d;
  logic                   pend_q, pend_d;
  logic [WAY_W-1:0]       proc_way_q, proc_way_d;
  logic                   done_q, done_d;
  logic                   hit_q, hit_d;
  logic                   evict_q, evict_d;
  logic [WAY_W-1:0]       way_q, way_d;
  logic [WAY_W-1:0]       oldest_q, oldest_d;
  logic [AGE_W-1:0]       oldest_age_q, oldest_age_d;
  logic [CNT_W-1:0]       hits_q, hits_d;
  logic [CNT_W-1:0]       acc_q, acc_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_hit_q, out_hit_d;
  logic [WAY_OUT_W-1:0]   out_way_q, out_way_d;
  logic                   out_evict_q, out_evict_d;

  // memory and way unit hookup
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  entry_t                 rd_ent;
  logic                   mem_we;
  logic                   tag_we;
  logic [ADDR_W-1:0]      wr_addr;
  entry_t                 wr_ent;
  way_res_t               unit_res;

  // address split helpers
  logic [SET_CFG_W-1:0]   sbits_eff;
  logic [4:0]             ways_raw;
  logic [4:0]             ways_eff;
  logic [ADDR_IN_W-1:0]   shifted;
  logic [ADDR_IN_W-1:0]   set_val;
  logic [5:0]             tag_sh;

  assign sbits_eff = (set_bits_q > SET_BITS_CAP) ? SET_BITS_CAP : set_bits_q;
  assign ways_raw  = 5'd1 << ways_log2_q;
  assign ways_eff  = (ways_raw > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : ways_raw;
  assign shifted   = addr_q >> offset_q;
  assign set_val   = shifted & ((32'd1 << sbits_eff) - 32'd1);
  assign tag_sh    = 6'(offset_q) + 6'(sbits_eff);

  sacl_mem #(
    .DEPTH  (ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_o      (rd_ent),
    .we_i      (mem_we),
    .tag_we_i  (tag_we),
    .wr_addr_i (wr_addr),
    .wr_i      (wr_ent)
  );

  sacl_way_unit u_way (
    .rd_i         (rd_ent),
    .tag_i        (tag_q),
    .done_i       (done_q),
    .first_i      (proc_way_q == '0),
    .oldest_age_i (oldest_age_q),
    .res_o        (unit_res)
  );

  // next-state logic of the sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    addr_d       = addr_q;
    tag_d        = tag_q;
    base_d       = base_q;
    ways_d       = ways_q;
    rd_cnt_d     = rd_cnt_q;
    pend_d       = pend_q;
    proc_way_d   = proc_way_q;
    done_d       = done_q;
    hit_d        = hit_q;
    evict_d      = evict_q;
    way_d        = way_q;
    oldest_d     = oldest_q;
    oldest_age_d = oldest_age_q;
    hits_d       = hits_q;
    acc_d        = acc_q;
    out_hit_d    = out_hit_q;
    out_way_d    = out_way_q;
    out_evict_d  = out_evict_q;
    out_valid_d  = out_valid_q && !rsp.ready;

    rd_en   = 1'b0;
    rd_addr = base_q + ADDR_W'(rd_cnt_q);
    mem_we  = 1'b0;
    tag_we  = 1'b0;
    wr_addr = base_q + ADDR_W'(proc_way_q);
    wr_ent  = unit_res.wr;

    unique case (state_q)
      S_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_q;
        wr_ent  = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == LAST_ENTRY) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          addr_d  = req.address;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        tag_d        = addr_q >> tag_sh;
        base_d       = ADDR_W'(set_val * 32'(MAX_WAYS));
        ways_d       = WAY_CNT_W'(ways_eff);
        rd_cnt_d     = '0;
        pend_d       = 1'b0;
        done_d       = 1'b0;
        hit_d        = 1'b0;
        evict_d      = 1'b0;
        oldest_d     = '0;
        oldest_age_d = '0;
        state_d      = S_SCAN;
      end
      S_SCAN: begin
        // fetch the next way while the previous one is judged
        if (rd_cnt_q != ways_q) begin
          rd_en      = 1'b1;
          rd_cnt_d   = rd_cnt_q + 1'b1;
          pend_d     = 1'b1;
          proc_way_d = rd_cnt_q[WAY_W-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          mem_we = 1'b1;
          tag_we = unit_res.tag_we;
          if (unit_res.hit || unit_res.fill) begin
            done_d = 1'b1;
            hit_d  = unit_res.hit;
            way_d  = proc_way_q;
          end
          if (unit_res.take) begin
            oldest_d     = proc_way_q;
            oldest_age_d = unit_res.aged;
          end
          if (rd_cnt_q == ways_q) begin
            state_d = (done_q || unit_res.hit || unit_res.fill) ? S_DONE : S_EVICT;
          end
        end
      end
      S_EVICT: begin
        // replace the oldest way of a full set
        mem_we       = 1'b1;
        tag_we       = 1'b1;
        wr_addr      = base_q + ADDR_W'(oldest_q);
        wr_ent.valid = 1'b1;
        wr_ent.tag   = tag_q;
        wr_ent.age   = '0;
        way_d        = oldest_q;
        evict_d      = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp.ready) begin
          hits_d      = hit_q ? sat_inc32(hits_q) : hits_q;
          acc_d       = sat_inc32(acc_q);
          out_hit_d   = hit_q;
          out_way_d   = WAY_OUT_W'(way_q);
          out_evict_d = evict_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      addr_q       <= '0;
      tag_q        <= '0;
      base_q       <= '0;
      ways_q       <= '0;
      rd_cnt_q     <= '0;
      pend_q       <= 1'b0;
      proc_way_q   <= '0;
      done_q       <= 1'b0;
      hit_q        <= 1'b0;
      evict_q      <= 1'b0;
      way_q        <= '0;
      oldest_q     <= '0;
      oldest_age_q <= '0;
      hits_q       <= '0;
      acc_q        <= '0;
      out_valid_q  <= 1'b0;
      out_hit_q    <= 1'b0;
      out_way_q    <= '0;
      out_evict_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      addr_q       <= addr_d;
      tag_q        <= tag_d;
      base_q       <= base_d;
      ways_q       <= ways_d;
      rd_cnt_q     <= rd_cnt_d;
      pend_q       <= pend_d;
      proc_way_q   <= proc_way_d;
      done_q       <= done_d;
      hit_q        <= hit_d;
      evict_q      <= evict_d;
      way_q        <= way_d;
      oldest_q     <= oldest_d;
      oldest_age_q <= oldest_age_d;
      hits_q       <= hits_d;
      acc_q        <= acc_d;
      out_valid_q  <= out_valid_d;
      out_hit_q    <= out_hit_d;
      out_way_q    <= out_way_d;
      out_evict_q  <= out_evict_d;
    end
  end

  // channel outputs
  assign req.ready        = (state_q == S_IDLE);
  assign rsp.valid        = out_valid_q;
  assign rsp.hit          = out_hit_q;
  assign rsp.way_used     = out_way_q;
  assign rsp.evicted      = out_evict_q;
  assign rsp.hit_count    = hits_q;
  assign rsp.access_count = acc_q;

`ifndef SYNTHESIS
  // a hit never reports an eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !(rsp.hit && rsp.evicted))
    else $error("response reports hit and eviction together");

  // hits can never outnumber accesses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> (rsp.access_count >= rsp.hit_count))
    else $error("hit count above access count");

  // a request keeps the block busy in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted on consecutive cycles");

  // a way under judgement lies inside the configured associativity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && pend_q) |-> (WAY_CNT_W'(proc_way_q) < ways_q))
    else $error("scanned way beyond ways in use");
`endif

endmodule

`default_nettype wire
